// ===== rtl/depth_slice_binning_core_macros.svh =====
// Assertion macros shared by the depth slice binning RTL.
`ifndef DEPTH_SLICE_BINNING_CORE_MACROS_SVH
`define DEPTH_SLICE_BINNING_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define DSB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define DSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DSB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DSB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/dsb_pkg.sv =====
`default_nettype none
package dsb_pkg;

  // Quotient bits, divisor magnitude bits and slice number width.
  localparam int QW = 48;
  localparam int DW = 50;
  localparam int SNW = 6;
  localparam int IDW = 16;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [IDW-1:0]     point_index;
  } in_t;

  typedef struct packed {
    logic [SNW-1:0] slice_number;
    logic [IDW-1:0] point_id;
    logic           last_of_run;
  } out_t;

  // Side information that rides along with the divider stages.
  typedef struct packed {
    logic [IDW-1:0] id;
    logic           zero;
    logic           neg_a;
    logic           neg_b;
  } side_t;

  typedef enum logic [2:0] {
    CFG_VIEW_X    = 3'd0,
    CFG_VIEW_Y    = 3'd1,
    CFG_VIEW_Z    = 3'd2,
    CFG_VIEW_OFF  = 3'd3,
    CFG_PROJ_SCL  = 3'd4,
    CFG_PROJ_OFF  = 3'd5,
    CFG_RADIUS    = 3'd6
  } cfg_idx_e;

endpackage
`default_nettype wire

// ===== rtl/dsb_div_pipe.sv =====
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, two divisors,
// one dividend; the user must keep it static while items are in flight.
module dsb_div_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [dsb_pkg::QW-1:0] dvd_i,
  input  logic [dsb_pkg::DW-1:0] dvs_a_i,
  input  logic [dsb_pkg::DW-1:0] dvs_b_i,
  input  dsb_pkg::side_t         side_i,
  output logic                   valid_o,
  output logic [dsb_pkg::QW-1:0] quo_a_o,
  output logic [dsb_pkg::QW-1:0] quo_b_o,
  output logic                   rem_nz_a_o,
  output logic                   rem_nz_b_o,
  output dsb_pkg::side_t         side_o
);

  localparam int QW = dsb_pkg::QW;
  localparam int DW = dsb_pkg::DW;

  logic [DW-1:0]  rem_a_q [QW];
  logic [DW-1:0]  rem_b_q [QW];
  logic [QW-1:0]  quo_a_q [QW];
  logic [QW-1:0]  quo_b_q [QW];
  logic [DW-1:0]  dvs_a_q [QW];
  logic [DW-1:0]  dvs_b_q [QW];
  dsb_pkg::side_t side_q  [QW];
  logic [QW-1:0]  vld_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0]  rem_a_in, rem_b_in, dvs_a_in, dvs_b_in;
    logic [QW-1:0]  quo_a_in, quo_b_in;
    dsb_pkg::side_t side_in;
    logic           vld_in;
    logic [DW:0]    tr_a, tr_b, sub_a, sub_b;
    logic           ge_a, ge_b;

    // Stage inputs come from the ports for the first stage.
    if (k == 0) begin : g_first
      assign rem_a_in = '0;
      assign rem_b_in = '0;
      assign quo_a_in = '0;
      assign quo_b_in = '0;
      assign dvs_a_in = dvs_a_i;
      assign dvs_b_in = dvs_b_i;
      assign side_in  = side_i;
      assign vld_in   = valid_i;
    end else begin : g_next
      assign rem_a_in = rem_a_q[k-1];
      assign rem_b_in = rem_b_q[k-1];
      assign quo_a_in = quo_a_q[k-1];
      assign quo_b_in = quo_b_q[k-1];
      assign dvs_a_in = dvs_a_q[k-1];
      assign dvs_b_in = dvs_b_q[k-1];
      assign side_in  = side_q[k-1];
      assign vld_in   = vld_q[k-1];
    end

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb begin
      tr_a  = {rem_a_in, dvd_i[QW-1-k]};
      tr_b  = {rem_b_in, dvd_i[QW-1-k]};
      ge_a  = tr_a >= {1'b0, dvs_a_in};
      ge_b  = tr_b >= {1'b0, dvs_b_in};
      sub_a = ge_a ? (tr_a - {1'b0, dvs_a_in}) : tr_a;
      sub_b = ge_b ? (tr_b - {1'b0, dvs_b_in}) : tr_b;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[k] <= sub_a[DW-1:0];
        rem_b_q[k] <= sub_b[DW-1:0];
        quo_a_q[k] <= {quo_a_in[QW-2:0], ge_a};
        quo_b_q[k] <= {quo_b_in[QW-2:0], ge_b};
        dvs_a_q[k] <= dvs_a_in;
        dvs_b_q[k] <= dvs_b_in;
        side_q[k]  <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[QW-1];
  assign quo_a_o    = quo_a_q[QW-1];
  assign quo_b_o    = quo_b_q[QW-1];
  assign rem_nz_a_o = |rem_a_q[QW-1];
  assign rem_nz_b_o = |rem_b_q[QW-1];
  assign side_o     = side_q[QW-1];

endmodule
`default_nettype wire

// ===== rtl/depth_slice_binning_core.sv =====
// An accepted item passes the front stages, the 48-stage divider and the back stages before
// its first result beat; output stalls add to this. Throughput: one item per cycle while
// items cover at most one slice and the output is not stalled; an item that covers N slices
// holds the output register, and so the whole pipeline, until its last beat is taken.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the register defaults.
`default_nettype none
`include "depth_slice_binning_core_macros.svh"
module depth_slice_binning_core #(
  parameter int SLICES     = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dsb_pkg::in_t           in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dsb_pkg::out_t          out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int QW   = dsb_pkg::QW;
  localparam int DW   = dsb_pkg::DW;
  localparam int SNW  = dsb_pkg::SNW;
  localparam int IDW  = dsb_pkg::IDW;
  localparam int SW   = 66;
  localparam int ZWW  = 50;
  localparam int DFW  = 51;
  localparam int QSW  = QW + 1;
  localparam int ZSW  = 51;
  localparam int WW   = 60;
  localparam int FW   = WW - 17;
  localparam logic signed [WW-1:0] SLC_W   = WW'(SLICES);
  localparam logic signed [WW-1:0] ONE_W   = WW'(65536);
  localparam logic signed [WW-1:0] RND_W   = WW'(131071);
  localparam logic signed [FW-1:0] LAST_F  = FW'(SLICES - 1);

  // Configuration registers.
  logic signed [31:0] vrx_q, vry_q, vrz_q, voff_q, pscl_q, poff_q;
  logic [30:0]        rad_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrx_q  <= '0;
      vry_q  <= '0;
      vrz_q  <= 32'sd65536;
      voff_q <= '0;
      pscl_q <= '0;
      poff_q <= '0;
      rad_q  <= 31'd6554;
    end else if (cfg_valid_i) begin
      unique case (dsb_pkg::cfg_idx_e'(cfg_index_i))
        dsb_pkg::CFG_VIEW_X:   vrx_q  <= cfg_data_i;
        dsb_pkg::CFG_VIEW_Y:   vry_q  <= cfg_data_i;
        dsb_pkg::CFG_VIEW_Z:   vrz_q  <= cfg_data_i;
        dsb_pkg::CFG_VIEW_OFF: voff_q <= cfg_data_i;
        dsb_pkg::CFG_PROJ_SCL: pscl_q <= cfg_data_i;
        dsb_pkg::CFG_PROJ_OFF: poff_q <= cfg_data_i;
        dsb_pkg::CFG_RADIUS:   rad_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register can take a new item.
  logic adv;
  logic out_valid_q;
  dsb_pkg::out_t out_q;
  logic [SNW-1:0] end_q;

  assign adv        = !out_valid_q || (out_ready_i && out_q.last_of_run);
  assign in_ready_o = adv;

  // Particle index masked to INDEX_BITS.
  logic [IDW-1:0] id_in;
  for (genvar b = 0; b < IDW; b++) begin : g_mask
    assign id_in[b] = (b < INDEX_BITS) ? in_data_i.point_index[b] : 1'b0;
  end

  // Valid bits of the front stages and the back stages.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic [IDW-1:0] id1_q, id2_q, id3_q, id4_q;

  // Stage 1: three products.
  logic signed [63:0] px_q, py_q, pz_q;
  // Stage 2: exact sum of the products.
  logic signed [SW-1:0] sum_q;
  // Stage 3: eye depth.
  logic signed [ZWW-1:0] zw_q;
  // Stage 4: front and back depths.
  logic signed [DFW-1:0] dfr_q, dbk_q;
  // Stage 5: divisor magnitudes and signs.
  logic [DW-1:0]  mag_a_q, mag_b_q;
  dsb_pkg::side_t side5_q;

  logic [31:0]    poff_mag;
  logic [QW-1:0]  dvd;

  always_comb begin
    poff_mag = poff_q[31] ? (32'd0 - poff_q) : poff_q;
    dvd      = {poff_mag, 16'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q    <= vrx_q * in_data_i.pos_x;
      py_q    <= vry_q * in_data_i.pos_y;
      pz_q    <= vrz_q * in_data_i.pos_z;
      id1_q   <= id_in;
      sum_q   <= SW'(px_q) + SW'(py_q) + SW'(pz_q);
      id2_q   <= id1_q;
      zw_q    <= ZWW'(sum_q >>> 16) + ZWW'(voff_q);
      id3_q   <= id2_q;
      dfr_q   <= DFW'(zw_q) + DFW'($signed({1'b0, rad_q}));
      dbk_q   <= DFW'(zw_q) - DFW'($signed({1'b0, rad_q}));
      id4_q   <= id3_q;
      mag_a_q <= DW'(dfr_q[DFW-1] ? (-dfr_q) : dfr_q);
      mag_b_q <= DW'(dbk_q[DFW-1] ? (-dbk_q) : dbk_q);
      side5_q <= '{id:    id4_q,
                   zero:  (dfr_q == '0) || (dbk_q == '0),
                   neg_a: poff_q[31] ^ dfr_q[DFW-1],
                   neg_b: poff_q[31] ^ dbk_q[DFW-1]};
    end
  end

  // Divider pipeline.
  logic           dv_valid;
  logic [QW-1:0]  quo_a, quo_b;
  logic           nz_a, nz_b;
  dsb_pkg::side_t dv_side;

  dsb_div_pipe u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (v5_q),
    .dvd_i      (dvd),
    .dvs_a_i    (mag_a_q),
    .dvs_b_i    (mag_b_q),
    .side_i     (side5_q),
    .valid_o    (dv_valid),
    .quo_a_o    (quo_a),
    .quo_b_o    (quo_b),
    .rem_nz_a_o (nz_a),
    .rem_nz_b_o (nz_b),
    .side_o     (dv_side)
  );

  // Back stages: floored quotient, clip depth, slice position, slice bounds, clamped bounds.
  logic signed [QSW-1:0] qa_q, qb_q;
  logic signed [ZSW-1:0] zsa_q, zsb_q;
  logic signed [WW-1:0]  wa_q, wb_q;
  logic signed [FW-1:0]  first_q, last_q;
  logic [IDW-1:0]        id6_q, id7_q, id8_q, id9_q, id10_q;
  logic                  z6_q, z7_q, z8_q, z9_q;
  logic [SNW-1:0]        first10_q, last10_q;
  logic                  empty10_q;

  logic signed [QSW-1:0] qa_u, qb_u;
  logic signed [WW-1:0]  wa_d, wb_d, rnd_a;
  logic signed [FW-1:0]  first_cl, last_cl;

  always_comb begin
    qa_u     = $signed({1'b0, quo_a});
    qb_u     = $signed({1'b0, quo_b});
    wa_d     = (WW'(ONE_W) - WW'(zsa_q)) * SLC_W - ONE_W;
    wb_d     = (WW'(ONE_W) - WW'(zsb_q)) * SLC_W - ONE_W;
    rnd_a    = wa_q + RND_W;
    first_cl = first_q[FW-1] ? '0 : first_q;
    last_cl  = (last_q > LAST_F) ? LAST_F : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else if (adv) begin
      v6_q  <= dv_valid;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qa_q      <= dv_side.neg_a ? (-qa_u - QSW'(nz_a)) : qa_u;
      qb_q      <= dv_side.neg_b ? (-qb_u - QSW'(nz_b)) : qb_u;
      id6_q     <= dv_side.id;
      z6_q      <= dv_side.zero;
      zsa_q     <= ZSW'(pscl_q) + ZSW'(qa_q);
      zsb_q     <= ZSW'(pscl_q) + ZSW'(qb_q);
      id7_q     <= id6_q;
      z7_q      <= z6_q;
      wa_q      <= wa_d;
      wb_q      <= wb_d;
      id8_q     <= id7_q;
      z8_q      <= z7_q;
      first_q   <= rnd_a[WW-1:17];
      last_q    <= wb_q[WW-1:17];
      id9_q     <= id8_q;
      z9_q      <= z8_q;
      first10_q <= first_cl[SNW-1:0];
      last10_q  <= last_cl[SNW-1:0];
      empty10_q <= z9_q || (first_cl > last_cl);
      id10_q    <= id9_q;
    end
  end

  // Output register steps through the covered slices of one item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v10_q && !empty10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.slice_number <= first10_q;
      out_q.point_id     <= id10_q;
      out_q.last_of_run  <= first10_q == last10_q;
      end_q              <= last10_q;
    end else if (out_ready_i) begin
      out_q.slice_number <= out_q.slice_number + 1'b1;
      out_q.last_of_run  <= (out_q.slice_number + 1'b1) == end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A run that is not finished keeps the output valid.
  `DSB_ASSERT_NEXT(a_run_continues, clk_i, rst_ni,
    out_valid_o && out_ready_i && !out_data_o.last_of_run, out_valid_o)
  // Consecutive beats of one run step through adjacent slices.
  `DSB_ASSERT_NEXT(a_slice_steps, clk_i, rst_ni,
    out_valid_o && out_ready_i && !out_data_o.last_of_run,
    out_data_o.slice_number == $past(out_data_o.slice_number) + 1'b1)
  // The pipeline never stalls while the output register is empty.
  `DSB_ASSERT_SAME(a_no_idle_stall, clk_i, rst_ni, !out_valid_o, in_ready_o)
  // Emitted slices stay inside the slice range.
  `DSB_ASSERT_SAME(a_slice_range, clk_i, rst_ni, out_valid_o,
    out_data_o.slice_number <= SNW'(SLICES - 1))

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index with no register behind it; writes to it are dropped.
  localparam logic [2:0] CFG_NONE = 3'd7;
  localparam int NSLICE = 64;
  localparam int DRAIN_CYCLES = 70;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES = 6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dsb_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dsb_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  depth_slice_binning_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic signed [31:0] row_x = 0, row_y = 0, row_z = 65536, eye_off = 0;
  logic signed [31:0] clip_scale = 0, clip_num = 0;
  logic [30:0] radius = 6554;

  dsb_pkg::out_t slice_beats[$];
  int errors = 0;
  bit burst = 0;
  bit hold_out_req = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // Slice position scaled by 2^17 for a nonzero front or back depth.
  function automatic logic signed [127:0] slice_pos(input logic signed [127:0] depth);
    logic signed [127:0] num, quo, zs;
    num = 128'(clip_num) * 65536;
    quo = num / depth;
    if ((num % depth) != 0 && ((num < 0) != (depth < 0))) quo = quo - 1;
    zs = 128'(clip_scale) + quo;
    return (65536 - zs) * NSLICE - 65536;
  endfunction

  // Expected slice beats for one sphere, appended to the queue.
  task automatic bin_sphere(input dsb_pkg::in_t d);
    logic signed [127:0] acc, zw, front, back, first, last;
    dsb_pkg::out_t o;
    acc = 128'(row_x) * 128'(d.pos_x) + 128'(row_y) * 128'(d.pos_y)
        + 128'(row_z) * 128'(d.pos_z);
    zw = (acc >>> 16) + 128'(eye_off);
    front = zw + $signed({97'd0, radius});
    back = zw - $signed({97'd0, radius});
    if (front == 0 || back == 0) return;
    first = -((-slice_pos(front)) >>> 17);
    last = slice_pos(back) >>> 17;
    if (first < 0) first = 0;
    if (last > NSLICE - 1) last = NSLICE - 1;
    for (logic signed [127:0] s = first; s <= last; s++) begin
      o.slice_number = s[dsb_pkg::SNW-1:0];
      o.point_id = d.point_index;
      o.last_of_run = (s == last);
      slice_beats.push_back(o);
    end
  endtask

  // Wait until all expected beats are out, then let the pipeline drain.
  task automatic wait_idle();
    while (slice_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register beat; the caller drops valid after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dsb_pkg::CFG_VIEW_X:   row_x = val;
      dsb_pkg::CFG_VIEW_Y:   row_y = val;
      dsb_pkg::CFG_VIEW_Z:   row_z = val;
      dsb_pkg::CFG_VIEW_OFF: eye_off = val;
      dsb_pkg::CFG_PROJ_SCL: clip_scale = val;
      dsb_pkg::CFG_PROJ_OFF: clip_num = val;
      dsb_pkg::CFG_RADIUS:   radius = val[30:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] vx, vy, vz, voff, pscl, poff, rad);
    write_reg(dsb_pkg::CFG_VIEW_X, vx);
    write_reg(dsb_pkg::CFG_VIEW_Y, vy);
    write_reg(dsb_pkg::CFG_VIEW_Z, vz);
    write_reg(dsb_pkg::CFG_VIEW_OFF, voff);
    write_reg(dsb_pkg::CFG_PROJ_SCL, pscl);
    write_reg(dsb_pkg::CFG_PROJ_OFF, poff);
    write_reg(dsb_pkg::CFG_RADIUS, rad);
    write_reg(CFG_NONE, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one sphere and predict its beats when it is accepted.
  task automatic send_sphere(input dsb_pkg::in_t d, input bit typed_empty);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    if (!typed_empty) bin_sphere(d);
  endtask

  function automatic logic [31:0] near_val(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  typedef struct {
    dsb_pkg::in_t d;
    bit typed_empty;
  } dir_row_t;

  // Directed rows; typed_empty marks a zero divisor known to emit nothing.
  dir_row_t dir_rows[] = '{
    '{'{32'sd0, 32'sd0, 32'sd65536, 16'h0000}, 1'b0},
    '{'{32'sd0, 32'sd0, 32'sd6554, 16'h1234}, 1'b1},
    '{'{32'sd0, 32'sd0, -32'sd6554, 16'hffff}, 1'b1},
    '{'{32'sd0, 32'sd0, 32'sd65536, 16'hffff}, 1'b0},
    '{'{32'sd0, 32'sd0, 32'sd72090, 16'h0001}, 1'b0},
    '{'{32'sd0, 32'sd0, -32'sd65536, 16'h00ff}, 1'b0},
    '{'{32'h7fffffff, 32'sd0, 32'sd65536, 16'h8000}, 1'b0},
    '{'{32'h80000000, 32'sd0, 32'sd65536, 16'h7fff}, 1'b0},
    '{'{32'sd0, 32'h7fffffff, 32'sd65536, 16'h5555}, 1'b0},
    '{'{32'sd0, 32'h80000000, 32'sd65536, 16'haaaa}, 1'b0},
    '{'{32'sd0, 32'sd0, 32'h7fffffff, 16'h0f0f}, 1'b0},
    '{'{32'sd0, 32'sd0, 32'h80000000, 16'hf0f0}, 1'b0},
    '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff}, 1'b0},
    '{'{32'h80000000, 32'h80000000, 32'h80000000, 16'h0000}, 1'b0},
    '{'{32'sd3277, -32'sd3277, 32'sd131072, 16'h4242}, 1'b0}
  };

  // Stimulus.
  initial begin
    dsb_pkg::in_t d;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults after reset give an empty slice range.
    send_sphere(dir_rows[0].d, 1'b0);
    send_sphere(dir_rows[3].d, 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();

    write_all(32'h100, 32'hffffff00, 32'd65536, 32'd0, 32'd0, 32'hffff0000, 32'd6554);
    foreach (dir_rows[i]) send_sphere(dir_rows[i].d, dir_rows[i].typed_empty);
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        3: write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h80000000, 32'h0);
        default: write_all(near_val(32'h2000), near_val(32'h2000),
                           32'd65536 + near_val(32'h4000), near_val(32'h20000),
                           near_val(32'h8000),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h80000)
                                                       : -$urandom_range(1, 32'h80000),
                           $urandom_range(0, 32'h20000));
      endcase
      burst = (ph % 3 == 2);
      if (ph == 0) hold_out_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          d = {$urandom, $urandom, $urandom, 16'($urandom)};
        end else begin
          d.pos_x = near_val(32'h40000);
          d.pos_y = near_val(32'h40000);
          d.pos_z = near_val(32'h40000);
          d.point_index = 16'($urandom);
        end
        send_sphere(d, 1'b0);
      end
      in_valid_i <= 1'b0;
    end

    while (slice_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output side: random stalls plus one long hold-off.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare each output beat with the oldest expected one.
  always @(posedge clk_i) begin
    dsb_pkg::out_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (slice_beats.size() == 0) begin
        report($sformatf("unexpected beat slice %0d id %h",
                         out_data_o.slice_number, out_data_o.point_id));
      end else begin
        exp_beat = slice_beats.pop_front();
        if (out_data_o.slice_number !== exp_beat.slice_number)
          report($sformatf("slice_number %0d, expected %0d",
                           out_data_o.slice_number, exp_beat.slice_number));
        if (out_data_o.point_id !== exp_beat.point_id)
          report($sformatf("point_id %h, expected %h",
                           out_data_o.point_id, exp_beat.point_id));
        if (out_data_o.last_of_run !== exp_beat.last_of_run)
          report($sformatf("last_of_run %b, expected %b",
                           out_data_o.last_of_run, exp_beat.last_of_run));
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
